[rtl/i6t_pkg.sv]
package i6t_pkg;

	localparam int GroupCount = 8;
	localparam logic [3:0] NoRun = 4'd8;
	localparam logic [7:0] MaxPrefix = 8'd128;

	localparam logic [6:0] CharNull  = 7'h00;
	localparam logic [6:0] CharColon = 7'h3a;
	localparam logic [6:0] CharSlash = 7'h2f;
	localparam logic [6:0] CharZero  = 7'h30;
	localparam logic [6:0] CharOne   = 7'h31;
	localparam logic [6:0] CharLowA  = 7'h61;

	typedef struct packed {
		logic bad;
		logic pfx;
		logic [GroupCount-1:0][15:0] grp;
		logic [3:0] run_start;
		logic [3:0] run_len;
		logic has_h;
		logic has_t;
		logic [3:0] tens;
		logic [3:0] ones;
	} entry_t;

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			hex_char = CharZero + {3'd0, nib};
		end else begin
			hex_char = CharLowA + {3'd0, nib} - 7'd10;
		end
	endfunction

	// Index of the most significant nonzero nibble; zero for an all-zero group.
	function automatic logic [1:0] lead_digit(input logic [15:0] grp);
		if (grp[15:12] != 4'd0) begin
			lead_digit = 2'd3;
		end else if (grp[11:8] != 4'd0) begin
			lead_digit = 2'd2;
		end else if (grp[7:4] != 4'd0) begin
			lead_digit = 2'd1;
		end else begin
			lead_digit = 2'd0;
		end
	endfunction

endpackage

[rtl/i6t_front.sv]
module i6t_front (
	input  logic [63:0]      addr_high,
	input  logic [63:0]      addr_low,
	input  logic             with_prefix,
	input  logic [7:0]       prefix_length,
	output i6t_pkg::entry_t  entry
);

	logic [127:0] keep;
	logic [127:0] addr;
	logic [7:0]   zero;
	logic [3:0]   len [8];
	logic         run;
	logic [3:0]   best_len;
	logic [3:0]   best_start;
	logic         hund;
	logic [6:0]   rem;
	logic [14:0]  prod;
	logic [3:0]   tens;
	logic [6:0]   ones_w;

	always_comb begin
		for (int i = 0; i < 128; i++) begin
			keep[127-i] = !with_prefix || (8'(i) < prefix_length);
		end
		addr = {addr_high, addr_low} & keep;
		for (int n = 0; n < i6t_pkg::GroupCount; n++) begin
			zero[n] = (addr[127-16*n -: 16] == 16'd0);
		end
	end

	always_comb begin
		for (int s = 0; s < i6t_pkg::GroupCount; s++) begin
			run = 1'b1;
			len[s] = 4'd0;
			for (int k = 0; k < i6t_pkg::GroupCount; k++) begin
				if (k >= s) begin
					run = run & zero[k];
					if (run) begin
						len[s] = len[s] + 4'd1;
					end
				end
			end
		end
		best_len = 4'd1;
		best_start = i6t_pkg::NoRun;
		for (int s = 0; s < i6t_pkg::GroupCount; s++) begin
			if (len[s] > best_len) begin
				best_len = len[s];
				best_start = 4'(s);
			end
		end
	end

	always_comb begin
		hund = (prefix_length >= 8'd100);
		rem = hund ? 7'(prefix_length - 8'd100) : prefix_length[6:0];
		prod = 15'(rem) * 15'd205;
		tens = prod[14:11];
		ones_w = rem - 7'(tens) * 7'd10;
	end

	always_comb begin
		entry.bad = with_prefix && (prefix_length > i6t_pkg::MaxPrefix);
		entry.pfx = with_prefix;
		for (int n = 0; n < i6t_pkg::GroupCount; n++) begin
			entry.grp[n] = addr[127-16*n -: 16];
		end
		entry.run_start = best_start;
		entry.run_len = best_len;
		entry.has_h = hund;
		entry.has_t = (prefix_length >= 8'd10);
		entry.tens = tens;
		entry.ones = ones_w[3:0];
	end

endmodule

[rtl/i6t_queue.sv]
module i6t_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  i6t_pkg::entry_t  wr_data,
	input  logic             rd_en,
	output i6t_pkg::entry_t  rd_data,
	output logic             full,
	output logic             empty
);

	i6t_pkg::entry_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) (full && !rd_en) |-> !wr_en)
		else $error("Write into a full queue.");
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> !rd_en)
		else $error("Read from an empty queue.");

endmodule

[rtl/i6t_back.sv]
module i6t_back (
	input  logic             clk,
	input  logic             arst_n,
	input  i6t_pkg::entry_t  head,
	input  logic             have,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output logic [6:0]       char_code,
	output logic             last_char,
	output logic             bad_prefix
);

	localparam logic [2:0] S_START = 3'd0;
	localparam logic [2:0] S_GRP   = 3'd1;
	localparam logic [2:0] S_DC    = 3'd2;
	localparam logic [2:0] S_COLON = 3'd3;
	localparam logic [2:0] S_SLASH = 3'd4;
	localparam logic [2:0] S_H     = 3'd5;
	localparam logic [2:0] S_T     = 3'd6;
	localparam logic [2:0] S_O     = 3'd7;

	logic [2:0] st_q;
	logic [3:0] g_q;
	logic [1:0] d_q;
	logic       out_v_q;
	logic [6:0] char_q;
	logic       last_q;
	logic       bad_q;

	logic       adv;
	logic [2:0] eff_st;
	logic [3:0] eff_g;
	logic [1:0] eff_d;
	logic [15:0] cur_grp;
	logic [3:0] nib;
	logic [2:0] nst;
	logic [3:0] ng;
	logic [1:0] nd;
	logic [6:0] ch;
	logic       last;
	logic       bad;
	logic       jump;
	logic       tail;

	assign adv = have && (!out_v_q || pop);
	assign q_pop = adv && last;
	assign empty = !out_v_q;
	assign char_code = char_q;
	assign last_char = last_q;
	assign bad_prefix = bad_q;

	always_comb begin
		if (st_q == S_START) begin
			eff_st = S_GRP;
			eff_g = 4'd0;
			eff_d = i6t_pkg::lead_digit(head.grp[0]);
		end else begin
			eff_st = st_q;
			eff_g = g_q;
			eff_d = d_q;
		end
		cur_grp = head.grp[eff_g[2:0]];
		nib = cur_grp[{eff_d, 2'b00} +: 4];
	end

	always_comb begin
		ch = i6t_pkg::CharNull;
		last = 1'b0;
		bad = 1'b0;
		nst = eff_st;
		ng = eff_g;
		nd = eff_d;
		jump = 1'b0;
		tail = 1'b0;
		if (st_q == S_START && head.bad) begin
			last = 1'b1;
			bad = 1'b1;
		end else begin
			unique case (eff_st)
				S_GRP: begin
					if (eff_g == head.run_start) begin
						ch = i6t_pkg::CharColon;
						if (eff_g == 4'd0) begin
							nst = S_DC;
						end else begin
							jump = 1'b1;
						end
					end else begin
						ch = i6t_pkg::hex_char(nib);
						if (eff_d == 2'd0) begin
							ng = eff_g + 4'd1;
							if (ng == 4'(i6t_pkg::GroupCount)) begin
								tail = 1'b1;
							end else begin
								nst = S_COLON;
							end
						end else begin
							nd = eff_d - 2'd1;
						end
					end
				end
				S_DC: begin
					ch = i6t_pkg::CharColon;
					jump = 1'b1;
				end
				S_COLON: begin
					ch = i6t_pkg::CharColon;
					nst = S_GRP;
					nd = i6t_pkg::lead_digit(cur_grp);
				end
				S_SLASH: begin
					ch = i6t_pkg::CharSlash;
					nst = head.has_h ? S_H : (head.has_t ? S_T : S_O);
				end
				S_H: begin
					ch = i6t_pkg::CharOne;
					nst = S_T;
				end
				S_T: begin
					ch = i6t_pkg::CharZero + {3'd0, head.tens};
					nst = S_O;
				end
				S_O: begin
					ch = i6t_pkg::CharZero + {3'd0, head.ones};
					last = 1'b1;
				end
				default: begin
					ch = i6t_pkg::CharNull;
				end
			endcase
			if (jump) begin
				ng = eff_g + head.run_len;
				if (ng == 4'(i6t_pkg::GroupCount)) begin
					tail = 1'b1;
				end else begin
					nst = S_GRP;
					nd = i6t_pkg::lead_digit(head.grp[ng[2:0]]);
				end
			end
			if (tail) begin
				if (head.pfx) begin
					nst = S_SLASH;
				end else begin
					last = 1'b1;
				end
			end
		end
		if (last) begin
			nst = S_START;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			char_q <= ch;
			last_q <= last;
			bad_q <= bad;
			g_q <= ng;
			d_q <= nd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_START;
			out_v_q <= 1'b0;
		end else begin
			if (adv) begin
				st_q <= nst;
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && bad_q) |-> (last_q && char_q == i6t_pkg::CharNull))
		else $error("An error result must be a single empty character.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_GRP || st_q == S_COLON) |-> (g_q < 4'(i6t_pkg::GroupCount)))
		else $error("Group index ran past the address.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_DC) |-> (have && g_q == 4'd0 && head.run_start == 4'd0))
		else $error("Leading double colon without a leading zero run.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_START) |-> have)
		else $error("Address text in progress without a queued address.");

endmodule

[rtl/ipv6_address_to_text.sv]
// Throughput: one character per cycle while pop does not hold the result port, set
// by the single character sequencer; an address yields 1 to 43 characters. A two-entry
// queue lets input transfers continue while the sequencer works. Reset (arst_n low)
// empties the queue, returns the sequencer to its start state and drops the pending
// result.
module ipv6_address_to_text (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] addr_high,
	input  logic [63:0] addr_low,
	input  logic        with_prefix,
	input  logic [7:0]  prefix_length,
	output logic        empty,
	input  logic        pop,
	output logic [6:0]  char_code,
	output logic        last_char,
	output logic        bad_prefix
);

	i6t_pkg::entry_t new_entry;
	i6t_pkg::entry_t head;
	logic            q_empty;
	logic            q_pop;
	logic            wr_en;

	assign wr_en = push && !full;

	i6t_front u_front (
		.addr_high     (addr_high),
		.addr_low      (addr_low),
		.with_prefix   (with_prefix),
		.prefix_length (prefix_length),
		.entry         (new_entry)
	);

	i6t_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (new_entry),
		.rd_en   (q_pop),
		.rd_data (head),
		.full    (full),
		.empty   (q_empty)
	);

	i6t_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.have       (!q_empty),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.char_code  (char_code),
		.last_char  (last_char),
		.bad_prefix (bad_prefix)
	);

endmodule

[dv/ipv6_text_checker.sv]
`timescale 1ns / 1ps

module ipv6_text_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [63:0] addr_high,
	input  logic [63:0] addr_low,
	input  logic        with_prefix,
	input  logic [7:0]  prefix_length,
	input  logic        empty,
	input  logic        pop,
	input  logic [6:0]  char_code,
	input  logic        last_char,
	input  logic        bad_prefix,
	output int          fails,
	output int          pending,
	output int          chars_checked
);

	typedef struct packed {
		logic [6:0] code;
		logic       last;
		logic       bad;
	} text_char_t;

	text_char_t expected_text[$];

	function automatic logic [6:0] hex_digit(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return i6t_pkg::CharZero + 7'(nib);
		end
		return i6t_pkg::CharLowA + 7'(nib) - 7'd10;
	endfunction

	function automatic void render_address(input logic [63:0] hi, input logic [63:0] lo,
			input logic pfx, input logic [7:0] plen);
		logic [127:0] addr;
		logic [15:0] grp [i6t_pkg::GroupCount];
		logic [6:0] text [$];
		logic [3:0] nib;
		int best_start;
		int best_len;
		int n;
		int k;
		int d;
		bit started;
		text_char_t c;

		if (pfx && plen > i6t_pkg::MaxPrefix) begin
			c = '{code: i6t_pkg::CharNull, last: 1'b1, bad: 1'b1};
			expected_text.push_back(c);
			return;
		end
		addr = {hi, lo};
		if (pfx) begin
			addr &= ~({128{1'b1}} >> plen);
		end
		for (n = 0; n < i6t_pkg::GroupCount; n++) begin
			grp[n] = addr[127 - 16 * n -: 16];
		end

		best_start = -1;
		best_len = 1;
		n = 0;
		while (n < i6t_pkg::GroupCount) begin
			if (grp[n] != 16'd0) begin
				n++;
			end else begin
				k = n;
				while (k < i6t_pkg::GroupCount && grp[k] == 16'd0) begin
					k++;
				end
				if (k - n > best_len) begin
					best_start = n;
					best_len = k - n;
				end
				n = k;
			end
		end

		n = 0;
		while (n < i6t_pkg::GroupCount) begin
			if (n == best_start) begin
				if (n == 0) begin
					text.push_back(i6t_pkg::CharColon);
				end
				text.push_back(i6t_pkg::CharColon);
				n += best_len;
			end else begin
				started = 0;
				for (d = 3; d >= 0; d--) begin
					nib = grp[n][4 * d +: 4];
					if (nib != 4'd0 || started || d == 0) begin
						text.push_back(hex_digit(nib));
						started = 1;
					end
				end
				n++;
				if (n != i6t_pkg::GroupCount) begin
					text.push_back(i6t_pkg::CharColon);
				end
			end
		end

		if (pfx) begin
			text.push_back(i6t_pkg::CharSlash);
			if (plen >= 8'd100) begin
				text.push_back(i6t_pkg::CharZero + 7'(plen / 100));
			end
			if (plen >= 8'd10) begin
				text.push_back(i6t_pkg::CharZero + 7'((plen / 10) % 10));
			end
			text.push_back(i6t_pkg::CharZero + 7'(plen % 10));
		end

		for (k = 0; k < text.size(); k++) begin
			c = '{code: text[k], last: (k == text.size() - 1), bad: 1'b0};
			expected_text.push_back(c);
		end
	endfunction

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (push && !full) begin
				render_address(addr_high, addr_low, with_prefix, prefix_length);
			end
			if (pop && !empty) begin
				chars_checked <= chars_checked + 1;
				if (expected_text.size() == 0) begin
					$display("%0t: character transfer with nothing expected: code %h last %b bad %b",
						$time, char_code, last_char, bad_prefix);
					fails <= fails + 1;
				end else begin
					want = expected_text.pop_front();
					if ({char_code, last_char, bad_prefix} !== want) begin
						$display("%0t: expected code %h last %b bad %b, got code %h last %b bad %b",
							$time, want.code, want.last, want.bad,
							char_code, last_char, bad_prefix);
						fails <= fails + 1;
					end
				end
			end
		end
		pending <= expected_text.size();
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int StallLimit = 5000;
	localparam int RandomItems = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [63:0] addr_high = '0;
	logic [63:0] addr_low = '0;
	logic        with_prefix = 1'b0;
	logic [7:0]  prefix_length = '0;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic [6:0]  char_code;
	logic        last_char;
	logic        bad_prefix;
	logic        steady = 1'b0;

	int fails;
	int pending;
	int chars_checked;
	int addresses_sent = 0;
	int prefixed_sent = 0;
	int rejected_sent = 0;
	int quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ipv6_address_to_text i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.addr_high     (addr_high),
		.addr_low      (addr_low),
		.with_prefix   (with_prefix),
		.prefix_length (prefix_length),
		.empty         (empty),
		.pop           (pop),
		.char_code     (char_code),
		.last_char     (last_char),
		.bad_prefix    (bad_prefix)
	);

	ipv6_text_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.addr_high     (addr_high),
		.addr_low      (addr_low),
		.with_prefix   (with_prefix),
		.prefix_length (prefix_length),
		.empty         (empty),
		.pop           (pop),
		.char_code     (char_code),
		.last_char     (last_char),
		.bad_prefix    (bad_prefix),
		.fails         (fails),
		.pending       (pending),
		.chars_checked (chars_checked)
	);

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= steady || ($urandom_range(0, 99) >= 36);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= StallLimit) begin
			$display("ipv6_address_to_text: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_address(input logic [63:0] hi, input logic [63:0] lo,
			input logic pfx, input logic [7:0] plen);
		while (!steady && $urandom_range(0, 99) < 36) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		addr_high <= hi;
		addr_low <= lo;
		with_prefix <= pfx;
		prefix_length <= plen;
		do begin
			@(posedge clk);
		end while (full);
		addresses_sent++;
		if (pfx) begin
			prefixed_sent++;
			if (plen > 8'd128) begin
				rejected_sent++;
			end
		end
	endtask

	function automatic logic [15:0] random_group();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			return 16'd0;
		end else if (pick < 6) begin
			return 16'($urandom_range(1, 15)) << (4 * $urandom_range(0, 3));
		end
		return 16'($urandom);
	endfunction

	initial begin
		logic [127:0] addr;
		logic pfx;
		logic [7:0] plen;
		int n;
		int g;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_address(64'h0, 64'h0, 1'b0, 8'd0);
		send_address('1, '1, 1'b0, 8'd0);
		send_address('1, '1, 1'b1, 8'd128);
		send_address('1, '1, 1'b1, 8'd0);
		send_address('1, '1, 1'b1, 8'd129);
		send_address('1, '1, 1'b1, 8'd255);
		send_address(64'h0, 64'h0, 1'b0, 8'd255);
		send_address('1, '1, 1'b1, 8'd64);
		send_address('1, '1, 1'b1, 8'd63);
		send_address('1, '1, 1'b1, 8'd65);
		send_address('1, '1, 1'b1, 8'd1);
		send_address('1, '1, 1'b1, 8'd127);
		send_address('1, '1, 1'b1, 8'd9);
		send_address('1, '1, 1'b1, 8'd99);
		send_address('1, '1, 1'b1, 8'd100);
		send_address(64'h0001_0000_0002_0003, 64'h0004_0005_0006_0007, 1'b0, 8'd0);
		send_address(64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004, 1'b0, 8'd0);
		send_address(64'h0001_0000_0000_0002, 64'h0000_0000_0000_0004, 1'b0, 8'd0);
		send_address(64'h0001_0002_0003_0004, 64'h0005_0006_0000_0000, 1'b0, 8'd0);
		send_address(64'h0000_0000_0001_0002, 64'h0003_0004_0005_0006, 1'b0, 8'd0);
		send_address(64'h0, 64'h0000_0000_0000_0001, 1'b0, 8'd0);
		send_address(64'h0abc_000f_00f0_0f00, 64'h8000_0000_a5a5_5a5a, 1'b0, 8'd0);
		send_address(64'h2001_0db8_ffff_ffff, 64'h1234_5678_9abc_def0, 1'b1, 8'd48);

		for (n = 0; n < RandomItems; n++) begin
			if (n == 150) begin
				steady <= 1'b1;
			end else if (n == 250) begin
				steady <= 1'b0;
			end
			for (g = 0; g < 8; g++) begin
				addr[127 - 16 * g -: 16] = random_group();
			end
			pfx = 1'($urandom_range(0, 1));
			plen = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(129, 255))
				: 8'($urandom_range(0, 128));
			send_address(addr[127:64], addr[63:0], pfx, plen);
		end
		push <= 1'b0;

		do begin
			@(posedge clk);
		end while (pending != 0);
		repeat (60) @(posedge clk);

		$display("Sent %0d addresses: %0d in prefix mode, %0d of them with an out-of-range length.",
			addresses_sent, prefixed_sent, rejected_sent);
		$display("Checked %0d character transfers against the predicted text.", chars_checked);
		if (fails == 0) begin
			$display("ipv6_address_to_text: match");
		end else begin
			$display("ipv6_address_to_text: mismatch");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/i6t_pkg.sv
rtl/i6t_front.sv
rtl/i6t_queue.sv
rtl/i6t_back.sv
rtl/ipv6_address_to_text.sv
dv/ipv6_text_checker.sv
dv/tb.sv
